[rtl/sme_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sme_pkg
// opcodes, status codes and fixed-point constants of the stack machine
// ---------------------------------------------------------------------------
package sme_pkg;

	localparam int DATA_W = 32;
	localparam int MODE_W = 5;
	localparam int TGT_W = 16;
	localparam int STAT_W = 3;

	localparam logic [MODE_W-1:0] OP_PUSH = 5'd0;
	localparam logic [MODE_W-1:0] OP_SAY  = 5'd1;
	localparam logic [MODE_W-1:0] OP_ADD  = 5'd2;
	localparam logic [MODE_W-1:0] OP_SUB  = 5'd3;
	localparam logic [MODE_W-1:0] OP_MUL  = 5'd4;
	localparam logic [MODE_W-1:0] OP_DIV  = 5'd5;
	localparam logic [MODE_W-1:0] OP_MOD  = 5'd6;
	localparam logic [MODE_W-1:0] OP_EQ   = 5'd7;
	localparam logic [MODE_W-1:0] OP_NE   = 5'd8;
	localparam logic [MODE_W-1:0] OP_LT   = 5'd9;
	localparam logic [MODE_W-1:0] OP_LE   = 5'd10;
	localparam logic [MODE_W-1:0] OP_GT   = 5'd11;
	localparam logic [MODE_W-1:0] OP_GE   = 5'd12;
	localparam logic [MODE_W-1:0] OP_JMP  = 5'd13;
	localparam logic [MODE_W-1:0] OP_JZ   = 5'd14;
	localparam logic [MODE_W-1:0] OP_RET  = 5'd15;

	localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
	localparam logic [STAT_W-1:0] ST_HALT  = 3'd1;
	localparam logic [STAT_W-1:0] ST_UNDER = 3'd2;
	localparam logic [STAT_W-1:0] ST_OVER  = 3'd3;
	localparam logic [STAT_W-1:0] ST_BADOP = 3'd4;
	localparam logic [STAT_W-1:0] ST_DIVZ  = 3'd5;

	localparam logic [DATA_W-1:0] Q_ONE  = 32'h0001_0000;
	localparam logic [DATA_W-1:0] Q_ZERO = 32'h0000_0000;
	localparam logic [DATA_W-1:0] Q_MAX  = 32'h7fff_ffff;
	localparam logic [DATA_W-1:0] Q_MIN  = 32'h8000_0000;

	typedef struct packed {
		logic start;
		logic is_mod;
	} div_ctl_t;

endpackage

[rtl/sme_divider.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sme_divider
// restoring divider, one quotient bit per cycle, magnitudes only
// ---------------------------------------------------------------------------
module sme_divider (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sme_pkg::div_ctl_t       ctl,
	input  logic [47:0]             dividend,
	input  logic [31:0]             divisor,
	output logic                    done,
	output logic [47:0]             quotient,
	output logic [31:0]             remainder
);
	import sme_pkg::*;

	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [47:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] dvs_q;
	logic [32:0] shifted;
	logic [32:0] diff;
	logic [5:0]  nbits;

	assign nbits = ctl.is_mod ? 6'd32 : 6'd48;
	assign shifted = {rem_q[31:0], quo_q[47]};
	assign diff = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q <= nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	// mod walks only the upper 32 bits of the dividend, which hold the operand magnitude
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			quo_q <= ctl.is_mod ? {dividend[47:16], 16'd0} : dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff;
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign remainder = rem_q[31:0];
endmodule

[rtl/stack_machine_executor_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stack_machine_executor_unit
// executes one bytecode instruction per transfer on a Q16.16 operand stack
// ---------------------------------------------------------------------------
// input channel: in_valid/in_ready with mode, jump_target, constant_value;
// one instruction per transfer, one result per instruction
// output channel: out_valid/out_ready with next_address, say_valid,
// say_value, depth_now and status
// the operand stack is a synchronous memory with a registered read port;
// the top of stack is cached in a register so binary ops read one entry
// from input transfer to out_valid: push, say, jmp, return and halting
// cases go through done; jump-if-false that refills the top through read
// and done; add/sub/compares and divide by zero through read, exec, done;
// mul adds mul before done, div/mod wait in div (one quotient bit a cycle)
// one instruction is in flight at a time; in_ready is high only when idle
// with the output register empty or being taken in the same cycle
// when the receiver stalls the result is held and the input stays blocked
// reset clears the state, stack pointer, instruction pointer, halted flag
// and out_valid; stack contents stay undefined until pushed
// ---------------------------------------------------------------------------
module stack_machine_executor_unit #(
	parameter int STACK_DEPTH = 64,
	parameter int ADDRESS_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [sme_pkg::MODE_W-1:0]    mode,
	input  logic [sme_pkg::TGT_W-1:0]     jump_target,
	input  logic signed [31:0]            constant_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [15:0]                   next_address,
	output logic                          say_valid,
	output logic signed [31:0]            say_value,
	output logic [6:0]                    depth_now,
	output logic [sme_pkg::STAT_W-1:0]    status
);
	import sme_pkg::*;

	localparam int SP_W = $clog2(STACK_DEPTH + 1);
	localparam int IX_W = $clog2(STACK_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV, S_DONE
	} state_t;

	state_t state_q;
	logic [SP_W-1:0] sp_q;
	logic [ADDRESS_BITS-1:0] ip_q;
	logic halted_q;
	logic [DATA_W-1:0] tos_q;
	logic [MODE_W-1:0] op_q;

	// stack memory, entries below the top; tos_q holds entry sp-1
	logic [DATA_W-1:0] mem [STACK_DEPTH];
	logic mem_we;
	logic [IX_W-1:0] mem_waddr, mem_raddr;
	logic [DATA_W-1:0] mem_wdata, mem_rdata_q;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		mem_rdata_q <= mem[mem_raddr];
	end

	// operands
	logic signed [DATA_W-1:0] a_s, b_s;
	logic a_neg, b_neg;
	logic [31:0] ma, mb;
	assign a_s = mem_rdata_q;
	assign b_s = tos_q;
	assign a_neg = a_s[31];
	assign b_neg = b_s[31];
	assign ma = a_neg ? 32'(-a_s) : a_s;
	assign mb = b_neg ? 32'(-b_s) : b_s;

	// multiply pipeline (one register after the multiplier)
	logic [63:0] prod_s1;
	logic neg_q;

	// divider
	div_ctl_t dctl;
	logic ddone;
	logic [47:0] dquo;
	logic [31:0] drem;
	sme_divider u_div (
		.clk(clk), .arst_n(arst_n), .ctl(dctl),
		.dividend({ma, 16'd0}), .divisor(mb),
		.done(ddone), .quotient(dquo), .remainder(drem)
	);

	// saturate a magnitude with sign to Q16.16
	function automatic logic [31:0] sat_mag(input logic [48:0] m, input logic neg);
		logic [31:0] r;
		if (neg) begin
			if (m >= 49'h0_8000_0000) r = Q_MIN;
			else r = 32'(-m[31:0]);
		end else begin
			if (m >= 49'h0_8000_0000) r = Q_MAX;
			else r = m[31:0];
		end
		return r;
	endfunction

	logic [32:0] sum33, dif33;
	assign sum33 = {a_s[31], a_s} + {b_s[31], b_s};
	assign dif33 = {a_s[31], a_s} - {b_s[31], b_s};

	function automatic logic [31:0] sat33(input logic [32:0] v);
		logic [31:0] r;
		if (v[32] != v[31]) r = v[32] ? Q_MIN : Q_MAX;
		else r = v[31:0];
		return r;
	endfunction

	logic [ADDRESS_BITS-1:0] ip_inc;
	assign ip_inc = ip_q + 1'b1;

	logic [SP_W-1:0] sp_dec;
	assign sp_dec = sp_q - 1'b1;

	logic [SP_W-1:0] sp_m2;
	assign sp_m2 = sp_q - SP_W'(2);

	// binary result
	logic cmp_t;
	always_comb begin
		unique case (op_q)
			OP_EQ: cmp_t = a_s == b_s;
			OP_NE: cmp_t = a_s != b_s;
			OP_LT: cmp_t = a_s < b_s;
			OP_LE: cmp_t = a_s <= b_s;
			OP_GT: cmp_t = a_s > b_s;
			default: cmp_t = a_s >= b_s;
		endcase
	end

	logic [48:0] mrnd;
	assign mrnd = 49'((prod_s1 + 64'h8000) >> 16);

	// output register must be empty or draining before a new transfer
	assign in_ready = (state_q == S_IDLE) && (!out_valid || out_ready);
	assign dctl.start = (state_q == S_EXEC) && mb != 0 && (op_q == OP_DIV || op_q == OP_MOD);
	assign dctl.is_mod = (op_q == OP_MOD);

	always_comb begin
		mem_raddr = IX_W'(sp_m2);
		mem_we = 1'b0;
		mem_waddr = IX_W'(sp_dec);
		mem_wdata = tos_q;
		// push spills the old top into memory
		if (in_valid && in_ready && !halted_q && mode == OP_PUSH
			&& sp_q != '0 && sp_q < SP_W'(STACK_DEPTH)) mem_we = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sp_q <= '0;
			ip_q <= '0;
			halted_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						op_q <= mode;
						say_valid <= 1'b0;
						say_value <= '0;
						state_q <= S_DONE;
						next_address <= 16'(ip_inc);
						depth_now <= 7'(sp_q);
						status <= ST_OK;
						if (halted_q) begin
							next_address <= 16'(ip_q);
							status <= ST_HALT;
						end else if (mode > OP_RET || mode == OP_RET) begin
							next_address <= 16'(ip_q);
							status <= (mode == OP_RET) ? ST_HALT : ST_BADOP;
							halted_q <= 1'b1;
						end else if (mode == OP_PUSH) begin
							if (sp_q >= SP_W'(STACK_DEPTH)) begin
								next_address <= 16'(ip_q);
								status <= ST_OVER;
								halted_q <= 1'b1;
							end else begin
								tos_q <= constant_value;
								sp_q <= sp_q + 1'b1;
								depth_now <= 7'(sp_q + 1'b1);
								ip_q <= ip_inc;
							end
						end else if (mode == OP_JMP) begin
							next_address <= 16'(ADDRESS_BITS'(jump_target));
							ip_q <= ADDRESS_BITS'(jump_target);
						end else if (mode == OP_SAY || mode == OP_JZ) begin
							if (sp_q == '0) begin
								next_address <= 16'(ip_q);
								status <= ST_UNDER;
								halted_q <= 1'b1;
							end else if (mode == OP_SAY) begin
								say_valid <= 1'b1;
								say_value <= tos_q;
								ip_q <= ip_inc;
							end else begin
								// pop; the entry under the top is read at this edge
								sp_q <= sp_dec;
								depth_now <= 7'(sp_dec);
								if (tos_q == '0) begin
									next_address <= 16'(ADDRESS_BITS'(jump_target));
									ip_q <= ADDRESS_BITS'(jump_target);
								end else ip_q <= ip_inc;
								if (sp_dec != '0) state_q <= S_READ;
							end
						end else begin
							if (sp_q < SP_W'(2)) begin
								next_address <= 16'(ip_q);
								status <= ST_UNDER;
								halted_q <= 1'b1;
							end else begin
								ip_q <= ip_inc;
								depth_now <= 7'(sp_dec);
								state_q <= S_READ;
							end
						end
					end
				end
				S_READ: begin
					// jump-if-false refills the top from the word read at accept
					if (op_q == OP_JZ) begin
						tos_q <= mem_rdata_q;
						state_q <= S_DONE;
					end else state_q <= S_EXEC;
				end
				S_EXEC: begin
					neg_q <= a_neg != b_neg;
					sp_q <= sp_dec;
					state_q <= S_DONE;
					priority case (op_q)
						OP_ADD: tos_q <= sat33(sum33);
						OP_SUB: tos_q <= sat33(dif33);
						OP_MUL: begin
							prod_s1 <= ma * mb;
							state_q <= S_MUL;
						end
						OP_DIV, OP_MOD: begin
							if (mb == '0) begin
								status <= ST_DIVZ;
								tos_q <= (op_q == OP_MOD || a_s == '0) ? Q_ZERO
									: (a_neg ? Q_MIN : Q_MAX);
							end else begin
								neg_q <= (op_q == OP_MOD) ? a_neg : (a_neg != b_neg);
								state_q <= S_DIV;
							end
						end
						default: tos_q <= cmp_t ? Q_ONE : Q_ZERO;
					endcase
				end
				S_MUL: begin
					tos_q <= sat_mag(mrnd, neg_q);
					state_q <= S_DONE;
				end
				S_DIV: begin
					if (ddone) begin
						tos_q <= (op_q == OP_MOD) ? sat_mag({17'd0, drem}, neg_q)
							: sat_mag({1'b0, dquo}, neg_q);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					out_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[rtl/sme_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sme_checker
// port-level checks of the stack machine executor
// ---------------------------------------------------------------------------
module sme_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        say_valid,
	input logic [31:0] say_value,
	input logic [2:0]  status,
	input logic [6:0]  depth_now
);
	import sme_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(say_value) && $stable(status))
		else $error("result changed while stalled");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_DIVZ)
		else $error("status code out of range");

	a_say_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !say_valid |-> say_value == '0)
		else $error("say value without say");

	a_say_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && say_valid |-> status == ST_OK && depth_now != '0)
		else $error("say with bad status or empty stack");

	// one instruction in flight: no transfer right after another
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready again right after a transfer");
endmodule

bind stack_machine_executor_unit sme_checker u_sme_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .say_valid(say_valid),
	.say_value(say_value), .status(status), .depth_now(depth_now)
);
